[hdl/ordered_list_head_tail_positional_delete_assert.svh]
// ----------------------------------------------------------------------------
// ordered list assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_HEAD_TAIL_POSITIONAL_DELETE_ASSERT_SVH
`define ORDERED_LIST_HEAD_TAIL_POSITIONAL_DELETE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define OLHT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("olht check failed");
// next-cycle implication
`define OLHT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("olht check failed");
`else
`define OLHT_ASSERT_IMP(label, ante, cons)
`define OLHT_ASSERT_NXT(label, ante, cons)
`endif

`endif

[hdl/olht_pkg.sv]
// ----------------------------------------------------------------------------
// olht_pkg
// shared types and codes of the ordered list block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olht_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		OP_FRONT = 2'd0,
		OP_BACK  = 2'd1,
		OP_DEL   = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADPOS = 2'd2
	} status_t;

	// compare results of the shared index unit
	typedef struct packed {
		logic eq_now;
		logic eq_next;
	} step_flags_t;

endpackage

[hdl/olht_req_if.sv]
// ----------------------------------------------------------------------------
// olht_req_if
// request channel: opcode and operand with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface olht_req_if
	import olht_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [1:0]               opcode;
	logic signed [DATA_W-1:0] operand;

	modport source (output valid, output opcode, output operand, input ready);
	modport sink (input valid, input opcode, input operand, output ready);
endinterface

[hdl/olht_rsp_if.sv]
// ----------------------------------------------------------------------------
// olht_rsp_if
// result channel: one list element per transfer with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface olht_rsp_if
	import olht_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] element;
	logic                     last_of_run;
	logic                     list_empty;
	logic [1:0]               status;

	modport source (
		output valid, output element, output last_of_run, output list_empty,
		output status, input ready
	);
	modport sink (
		input valid, input element, input last_of_run, input list_empty,
		input status, output ready
	);
endinterface

[hdl/olht_step_unit.sv]
// ----------------------------------------------------------------------------
// olht_step_unit
// shared index unit: step up or down by one and compare against a limit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olht_step_unit
	import olht_pkg::*;
#(
	parameter int unsigned CW = 6
) (
	input  logic [CW-1:0] idx,
	input  logic [CW-1:0] limit,
	input  logic          dn,
	output logic [CW-1:0] nxt,
	output step_flags_t   flags
);

	assign nxt = dn ? (idx - CW'(1)) : (idx + CW'(1));
	assign flags.eq_now  = (idx == limit);
	assign flags.eq_next = (nxt == limit);

endmodule

[hdl/ordered_list_head_tail_positional_delete.sv]
// ----------------------------------------------------------------------------
// ordered list with front insert, back append and positional delete
// after each request the whole list goes out on the result channel, front first,
// or a single empty marker; each moved entry passes a read and a write state
// throughput: one result per cycle while the result channel is not stalled; the
// block takes no new request until the listing of the current one is out
// entries move through the single memory port pair and the shared index unit
// reset: list count clears to zero; entry storage is not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_head_tail_positional_delete
	import olht_pkg::*;
#(
	parameter int unsigned DEPTH = 32
) (
	input logic clk,
	input logic arst_n,
	olht_req_if.sink   request,
	olht_rsp_if.source result
);

	`include "ordered_list_head_tail_positional_delete_assert.svh"

	localparam int unsigned CW = $clog2(DEPTH + 1);  // holds 0..DEPTH
	localparam int unsigned AW = $clog2(DEPTH);      // entry address

	// sequencer states, one-hot
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECIDE = 8'b0000_0010,
		S_SH_RD  = 8'b0000_0100,
		S_SH_WR  = 8'b0000_1000,
		S_PUT    = 8'b0001_0000,
		S_EM_RD  = 8'b0010_0000,
		S_EM_LD  = 8'b0100_0000,
		S_EM_NIL = 8'b1000_0000
	} state_t;

	state_t state_q;

	// request held for the whole run
	logic [1:0]        op_q;
	logic [DATA_W-1:0] opnd_q;
	status_t           status_q;

	// list bookkeeping
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] limit_q;

	// entry storage, slot 0 is the front
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;

	// output register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_elem_q;
	logic              out_last_q;
	logic              out_empty_q;
	status_t           out_status_q;
	logic              out_free;

	// shared index unit
	logic [CW-1:0] nxt;
	step_flags_t   flags;
	logic          step_dn;

	// delete position check against the current count
	logic          pos_ok;
	logic [CW-1:0] pos;

	// shifting toward the back walks down, everything else walks up
	assign step_dn = (op_q == OP_FRONT) && (state_q == S_SH_RD || state_q == S_SH_WR);

	olht_step_unit #(
		.CW(CW)
	) u_step (
		.idx  (idx_q),
		.limit(limit_q),
		.dn   (step_dn),
		.nxt  (nxt),
		.flags(flags)
	);

	// negative positions have the sign bit set and fail here
	assign pos_ok = !opnd_q[DATA_W-1] &&
		({1'b0, opnd_q[DATA_W-2:0]} < DATA_W'(count_q));
	assign pos    = opnd_q[CW-1:0];

	assign out_free        = !out_valid_q || result.ready;
	assign request.ready   = (state_q == S_IDLE);
	assign result.valid       = out_valid_q;
	assign result.element     = out_elem_q;
	assign result.last_of_run = out_last_q;
	assign result.list_empty  = out_empty_q;
	assign result.status      = out_status_q;

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = rdata_q;
		ram_re    = 1'b0;
		ram_raddr = nxt[AW-1:0];
		unique case (state_q)
			S_SH_RD: begin
				// fetch the neighbor that moves into slot idx
				ram_re = 1'b1;
			end
			S_SH_WR: begin
				ram_we = 1'b1;
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = (op_q == OP_FRONT) ? '0 : count_q[AW-1:0];
				ram_wdata = opnd_q;
			end
			S_EM_RD: begin
				// first element of the run
				ram_re    = 1'b1;
				ram_raddr = idx_q[AW-1:0];
			end
			S_EM_LD: begin
				// prefetch the next element as the current one is loaded out
				ram_re = out_free && !flags.eq_now;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			mem[ram_waddr] <= ram_wdata;
		end
		if (ram_re) begin
			rdata_q <= mem[ram_raddr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			limit_q     <= '0;
			status_q    <= ST_DONE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (request.valid) begin
						op_q    <= request.opcode;
						opnd_q  <= request.operand;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					status_q <= ST_DONE;
					idx_q    <= '0;
					state_q  <= S_EM_RD;
					if (op_q == OP_FRONT || op_q == OP_BACK) begin
						if (count_q == CW'(DEPTH)) begin
							status_q <= ST_FULL;
						end else if (op_q == OP_BACK || count_q == '0) begin
							state_q <= S_PUT;
						end else begin
							// move slots count-1 .. 0 up by one, from the back
							idx_q   <= count_q;
							limit_q <= '0;
							state_q <= S_SH_RD;
						end
					end else if (op_q == OP_DEL) begin
						if (!pos_ok) begin
							status_q <= ST_BADPOS;
						end else if (pos == count_q - CW'(1)) begin
							// deleting the tail moves nothing
							count_q <= count_q - CW'(1);
						end else begin
							idx_q   <= pos;
							limit_q <= count_q - CW'(1);
							state_q <= S_SH_RD;
						end
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					idx_q <= nxt;
					if (flags.eq_next) begin
						if (op_q == OP_FRONT) begin
							state_q <= S_PUT;
						end else begin
							count_q <= count_q - CW'(1);
							idx_q   <= '0;
							state_q <= S_EM_RD;
						end
					end else begin
						state_q <= S_SH_RD;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					idx_q   <= '0;
					state_q <= S_EM_RD;
				end
				S_EM_RD: begin
					limit_q <= count_q - CW'(1);
					state_q <= (count_q == '0) ? S_EM_NIL : S_EM_LD;
				end
				S_EM_LD: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_elem_q   <= rdata_q;
						out_last_q   <= flags.eq_now;
						out_empty_q  <= 1'b0;
						out_status_q <= status_q;
						if (flags.eq_now) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= nxt;
						end
					end
				end
				S_EM_NIL: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_elem_q   <= '0;
						out_last_q   <= 1'b1;
						out_empty_q  <= 1'b1;
						out_status_q <= status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`OLHT_ASSERT_IMP(a_count_range, 1'b1, count_q <= CW'(DEPTH))
	`OLHT_ASSERT_IMP(a_emit_in_range, state_q == S_EM_LD, idx_q < count_q)
	`OLHT_ASSERT_IMP(a_write_in_range, ram_we, ram_waddr <= AW'(DEPTH - 1))
	`OLHT_ASSERT_IMP(a_empty_is_last, out_valid_q && out_empty_q, out_last_q)
	`OLHT_ASSERT_NXT(a_count_step, state_q == S_IDLE, count_q == $past(count_q))

endmodule

[bench/ordered_list_head_tail_positional_delete_test.sv]
// ----------------------------------------------------------------------------
// ordered_list_head_tail_positional_delete_test
// self-checking bench for the ordered list: a directed run over the corner
// cases, then random requests that fill the list to the brim and drain it
// again. A shadow list predicts every listing that a request produces, and
// each result transfer is checked against it field by field. Both channels
// idle at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_head_tail_positional_delete_test
	import olht_pkg::*;
();

	localparam int LIST_DEPTH  = 32;
	localparam int RANDOM_REQS = 150;
	localparam int IDLE_LIMIT  = 1000;  // cycles with no transfer on either channel
	localparam int DRAIN_WAIT  = 100;   // wait for stray results after the last listing

	// the opcode field has one unused code, taken as a no-op
	localparam logic [1:0] OP_NOP = 2'd3;

	typedef struct {
		logic [1:0]               opcode;
		logic signed [DATA_W-1:0] operand;
	} list_req_t;

	typedef struct {
		logic signed [DATA_W-1:0] element;
		logic                     last_of_run;
		logic                     list_empty;
		status_t                  status;
	} list_entry_t;

	logic clk;
	logic arst_n;

	olht_req_if request ();
	olht_rsp_if result ();

	ordered_list_head_tail_positional_delete #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(request),
		.result(result)
	);

	// requests still to be sent, and the listing still to come back
	list_req_t   req_backlog[$];
	list_entry_t listing_due[$];

	// shadow of the list, updated on every accepted request
	logic signed [DATA_W-1:0] shadow_mem[LIST_DEPTH];
	int                       shadow_count;

	// element count as the request plan goes, used only to steer the stimulus
	int plan_count;

	int error_count;
	int idle_cycles;
	int send_gap;
	int recv_hold;
	int send_quiet;
	int recv_quiet;
	logic req_taken;

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// shadow list model
	// ------------------------------------------------------------------------

	// apply one request to the shadow list and queue the listing it produces
	function automatic void apply_request(input logic [1:0] op,
		input logic signed [DATA_W-1:0] arg);
		status_t     st;
		list_entry_t ent;
		int          i;
		st = ST_DONE;
		if (op == OP_FRONT || op == OP_BACK) begin
			if (shadow_count >= LIST_DEPTH) begin
				// full list: insert dropped, list unchanged
				st = ST_FULL;
			end else if (op == OP_FRONT) begin
				for (i = shadow_count; i > 0; i--)
					shadow_mem[i] = shadow_mem[i - 1];
				shadow_mem[0] = arg;
				shadow_count++;
			end else begin
				shadow_mem[shadow_count] = arg;
				shadow_count++;
			end
		end else if (op == OP_DEL) begin
			// negative positions and positions at or past the count are ignored
			if (arg < 0 || arg >= shadow_count) begin
				st = ST_BADPOS;
			end else begin
				for (i = arg; i + 1 < shadow_count; i++)
					shadow_mem[i] = shadow_mem[i + 1];
				shadow_count--;
			end
		end
		// unused opcode falls through: list listed unchanged, status done

		if (shadow_count == 0) begin
			ent.element     = '0;
			ent.last_of_run = 1'b1;
			ent.list_empty  = 1'b1;
			ent.status      = st;
			listing_due.push_back(ent);
		end else begin
			for (i = 0; i < shadow_count; i++) begin
				ent.element     = shadow_mem[i];
				ent.last_of_run = (i + 1 == shadow_count);
				ent.list_empty  = 1'b0;
				ent.status      = st;
				listing_due.push_back(ent);
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// stimulus planning
	// ------------------------------------------------------------------------

	// queue a request and follow the element count it leads to
	function automatic void plan_request(input logic [1:0] op,
		input logic signed [DATA_W-1:0] arg);
		list_req_t r;
		r.opcode  = op;
		r.operand = arg;
		req_backlog.push_back(r);
		if ((op == OP_FRONT || op == OP_BACK) && plan_count < LIST_DEPTH)
			plan_count++;
		else if (op == OP_DEL && arg >= 0 && arg < plan_count)
			plan_count--;
	endfunction

	// data value: mostly random, now and then one of the extremes
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// delete position that the list must refuse
	function automatic logic signed [DATA_W-1:0] pick_bad_pos();
		case ($urandom_range(0, 4))
			0: return plan_count;
			1: return -32'sd1;
			2: return 32'sh80000000;
			3: return plan_count + $urandom_range(1, 40);
			default: return $urandom | 32'h8000_0000;
		endcase
	endfunction

	function automatic logic [1:0] pick_insert_op();
		return $urandom_range(0, 1) ? OP_FRONT : OP_BACK;
	endfunction

	// idle cycles before the next item; quiet stretches have none at all
	function automatic int draw_wait(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 5) == 0) begin
			quiet_left = $urandom_range(5, 20);
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	task automatic build_directed();
		// empty list: a delete and a no-op each list nothing but the empty flag
		plan_request(OP_DEL, 32'sd0);
		plan_request(OP_NOP, 32'sd0);
		// extremes of the data field at both ends
		plan_request(OP_FRONT, 32'sh7fffffff);
		plan_request(OP_BACK, 32'sh80000000);
		plan_request(OP_FRONT, -32'sd1);
		plan_request(OP_BACK, 32'sd0);
		// no-op on a filled list
		plan_request(OP_NOP, 32'sh5a5a5a5a);
		// refused deletes: negative, most negative, equal to count, far past it
		plan_request(OP_DEL, -32'sd1);
		plan_request(OP_DEL, 32'sh80000000);
		plan_request(OP_DEL, 32'sd4);
		plan_request(OP_DEL, 32'sh7fffffff);
		// delete the tail, then append: the tail must have moved back
		plan_request(OP_DEL, 32'sd3);
		plan_request(OP_BACK, 32'sh00012345);
		// middle, front and tail deletes down to an empty list
		plan_request(OP_DEL, 32'sd1);
		plan_request(OP_DEL, 32'sd0);
		plan_request(OP_DEL, 32'sd1);
		plan_request(OP_DEL, 32'sd0);
		// single element in, out, and in again from the other end
		plan_request(OP_BACK, 32'sh2aaaaaaa);
		plan_request(OP_DEL, 32'sd0);
		plan_request(OP_FRONT, 32'sh55555555);
	endtask

	// random requests in fill and drain phases so the list hits both ends
	task automatic build_random();
		bit filling;
		int full_tries;
		int roll;
		int n;
		filling    = 1'b1;
		full_tries = 0;
		for (n = 0; n < RANDOM_REQS; n++) begin
			if (plan_count == 0)
				filling = 1'b1;
			if (plan_count == LIST_DEPTH) begin
				full_tries++;
				if (full_tries > 3) begin
					filling    = 1'b0;
					full_tries = 0;
				end
			end
			roll = $urandom_range(0, 99);
			if (filling) begin
				if (roll < 75)
					plan_request(pick_insert_op(), pick_value());
				else if (roll < 85 && plan_count > 0)
					plan_request(OP_DEL, $urandom_range(0, plan_count - 1));
				else if (roll < 95)
					plan_request(OP_DEL, pick_bad_pos());
				else
					plan_request(OP_NOP, $urandom);
			end else begin
				if (roll < 70 && plan_count > 0)
					plan_request(OP_DEL, $urandom_range(0, plan_count - 1));
				else if (roll < 85)
					plan_request(pick_insert_op(), pick_value());
				else if (roll < 95)
					plan_request(OP_DEL, pick_bad_pos());
				else
					plan_request(OP_NOP, $urandom);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want);
		$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
		error_count++;
	endtask

	task automatic check_result();
		list_entry_t want;
		if (listing_due.size() == 0) begin
			report_mismatch("unexpected result", result.element, '0);
		end else begin
			want = listing_due.pop_front();
			// element carries no meaning on an empty list
			if (!want.list_empty && result.element !== want.element)
				report_mismatch("element", result.element, want.element);
			if (result.last_of_run !== want.last_of_run)
				report_mismatch("last_of_run", DATA_W'(result.last_of_run),
					DATA_W'(want.last_of_run));
			if (result.list_empty !== want.list_empty)
				report_mismatch("list_empty", DATA_W'(result.list_empty),
					DATA_W'(want.list_empty));
			if (result.status !== want.status)
				report_mismatch("status", DATA_W'(result.status), DATA_W'(want.status));
		end
	endtask

	// ------------------------------------------------------------------------
	// request driver: one item per transfer, random gap before each
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request.valid   <= 1'b0;
			request.opcode  <= OP_FRONT;
			request.operand <= '0;
			send_gap        <= 0;
		end else begin
			req_taken = request.valid && request.ready;
			if (req_taken)
				apply_request(request.opcode, request.operand);
			// load the next item once the current one is gone
			if (!request.valid || req_taken) begin
				if (send_gap != 0) begin
					send_gap      <= send_gap - 1;
					request.valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					request.valid   <= 1'b1;
					request.opcode  <= req_backlog[0].opcode;
					request.operand <= req_backlog[0].operand;
					void'(req_backlog.pop_front());
					send_gap <= draw_wait(send_quiet);
				end else begin
					request.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// result monitor: checks each transfer, holds ready low at random
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			recv_hold = 0;
		end else begin
			if (result.valid && result.ready) begin
				check_result();
				recv_hold = draw_wait(recv_quiet);
			end
			if (recv_hold != 0) begin
				recv_hold--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: ends the run when neither channel moves for too long
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((request.valid && request.ready) || (result.valid && result.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("ordered_list_head_tail_positional_delete_test: done, errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// run control
	// ------------------------------------------------------------------------
	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		error_count  = 0;
		idle_cycles  = 0;
		shadow_count = 0;
		plan_count   = 0;
		send_quiet   = 0;
		recv_quiet   = 0;

		build_directed();
		build_random();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all requests sent and every listing back
		@(negedge clk);
		while (req_backlog.size() != 0 || request.valid || listing_due.size() != 0)
			@(negedge clk);

		// let any stray result show up before closing
		repeat (DRAIN_WAIT) @(negedge clk);

		if (error_count == 0) begin
			$display("ordered_list_head_tail_positional_delete_test: done, clean");
		end else begin
			$display("ordered_list_head_tail_positional_delete_test: done, errors");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/olht_pkg.sv
hdl/olht_req_if.sv
hdl/olht_rsp_if.sv
hdl/olht_step_unit.sv
hdl/ordered_list_head_tail_positional_delete.sv
bench/ordered_list_head_tail_positional_delete_test.sv
